// ===== rtl/dm64_pkg.sv =====
// ----------------------------------------------------------------------------
// dm64_pkg: shared types and constants for the 64-bit divide/modulo block
// Request and response beat layouts, data width and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dm64_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int STEP_WIDTH = $clog2(DATA_WIDTH);

  localparam logic [1:0] ACT_UQUO = 2'd0;
  localparam logic [1:0] ACT_UREM = 2'd1;
  localparam logic [1:0] ACT_SQUO = 2'd2;
  localparam logic [1:0] ACT_SREM = 2'd3;

  typedef struct packed {
    logic [1:0]            action;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    logic                  div_by_zero;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/dm64_alu.sv =====
// ----------------------------------------------------------------------------
// dm64_alu: shared 64-bit subtractor
// Computes a - b with a carry out that is set when a >= b (no borrow). Used
// for operand negation, each restoring-division step and result negation.
// ----------------------------------------------------------------------------
`default_nettype none

module dm64_alu (
  input  wire logic [dm64_pkg::DATA_WIDTH-1:0] a,
  input  wire logic [dm64_pkg::DATA_WIDTH-1:0] b,
  output logic      [dm64_pkg::DATA_WIDTH-1:0] diff,
  output logic                                 no_borrow
);
  import dm64_pkg::*;

  logic [DATA_WIDTH:0] sum;

  assign sum       = {1'b0, a} + {1'b0, ~b} + {{DATA_WIDTH{1'b0}}, 1'b1};
  assign diff      = sum[DATA_WIDTH-1:0];
  assign no_borrow = sum[DATA_WIDTH];

endmodule

`default_nettype wire

// ===== rtl/divide_modulo_64.sv =====
// ----------------------------------------------------------------------------
// divide_modulo_64: 64-bit unsigned/signed divide and modulo
// Restoring long division, one quotient bit per cycle on a shared subtractor.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. The answer appears on
// response with done high for exactly one cycle, after the block has passed
// through ST_NEGA (dividend magnitude), ST_NEGB (divisor magnitude), ST_DIV
// (64 division steps) and ST_FIX (signing the result), all on the
// single 64-bit subtractor. busy is low again in the cycle that done is high,
// so a new beat may be offered then and is taken at the edge that ends it; no
// new beat is taken while one is in progress.
// The receiver cannot stall the result. Division by zero gives an all-ones
// magnitude quotient and the dividend as the remainder, with div_by_zero set.
`default_nettype none

module divide_modulo_64 (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire dm64_pkg::req_t request,
  output logic                busy,
  output logic                done,
  output dm64_pkg::rsp_t      response
);
  import dm64_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEGA = 3'd1;
  localparam logic [2:0] ST_NEGB = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;

  logic [2:0]            state;
  logic [STEP_WIDTH-1:0] step;
  logic [DATA_WIDTH-1:0] quo;   // dividend shifts out the top, quotient in
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] den;
  logic                  is_signed;
  logic                  want_rem;
  logic                  neg_num;
  logic                  neg_den;
  logic                  zero;

  logic [DATA_WIDTH-1:0] alu_a;
  logic [DATA_WIDTH-1:0] alu_b;
  logic [DATA_WIDTH-1:0] alu_diff;
  logic                  alu_nb;
  logic [DATA_WIDTH-1:0] rem_shift;
  logic                  take;
  logic [DATA_WIDTH-1:0] final_val;
  logic                  final_neg;

  assign rem_shift = {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
  // The bit shifted out of the partial remainder makes it at least 2^64.
  assign take      = rem[DATA_WIDTH-1] | alu_nb;
  assign final_val = want_rem ? rem : quo;
  assign final_neg = want_rem ? (is_signed & neg_num)
                              : (is_signed & (neg_num ^ neg_den));

  always_comb begin
    alu_a = '0;
    alu_b = quo;
    unique case (state)
      ST_NEGA: begin
        alu_b = quo;
      end
      ST_NEGB: begin
        alu_b = den;
      end
      ST_DIV: begin
        alu_a = rem_shift;
        alu_b = den;
      end
      ST_FIX: begin
        alu_b = final_val;
      end
      default: begin
        alu_b = quo;
      end
    endcase
  end

  dm64_alu u_alu (
    .a         (alu_a),
    .b         (alu_b),
    .diff      (alu_diff),
    .no_borrow (alu_nb)
  );

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_NEGA;
          end
        end
        ST_NEGA: begin
          state <= ST_NEGB;
        end
        ST_NEGB: begin
          state <= ST_DIV;
          step  <= STEP_WIDTH'(DATA_WIDTH - 1);
        end
        ST_DIV: begin
          step <= step - STEP_WIDTH'(1);
          if (step == '0) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          quo       <= request.dividend;
          den       <= request.divisor;
          rem       <= '0;
          is_signed <= (request.action == ACT_SQUO) || (request.action == ACT_SREM);
          want_rem  <= (request.action == ACT_UREM) || (request.action == ACT_SREM);
          neg_num   <= request.dividend[DATA_WIDTH-1];
          neg_den   <= request.divisor[DATA_WIDTH-1];
          zero      <= (request.divisor == '0);
        end
      end
      ST_NEGA: begin
        if (is_signed && neg_num) begin
          quo <= alu_diff;
        end
      end
      ST_NEGB: begin
        if (is_signed && neg_den) begin
          den <= alu_diff;
        end
      end
      ST_DIV: begin
        rem <= take ? alu_diff : rem_shift;
        quo <= {quo[DATA_WIDTH-2:0], take};
      end
      ST_FIX: begin
        response.result      <= final_neg ? alu_diff : final_val;
        response.div_by_zero <= zero;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/tb_divide_modulo_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_divide_modulo_64: self-checking bench for the 64-bit divide/modulo block
// A short table of hand-picked beats (corners, divide by zero, most negative
// dividend, divisor larger than dividend) is followed by random beats in three
// phases of sender idling. Every answer is checked against its typed-in answer
// or a bit-exact long-division predictor kept in the bench.
// ----------------------------------------------------------------------------

module tb_divide_modulo_64;
  import dm64_pkg::*;

  localparam int RANDOM_BEATS = 1400;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    req_t rq;
    bit   known;
    rsp_t ans;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t response;

  rsp_t      answers_due[$];
  stim_row_t stim_table[$];
  int        idle_pct = 0;
  int        fail_count = 0;
  int        beats_sent = 0;
  int        results_seen = 0;
  int        zero_divs = 0;
  int        signed_beats = 0;
  int        idle_cycles = 0;

  divide_modulo_64 dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  always #6 clk = ~clk;

  // Truncating division on operand magnitudes, one quotient bit per step.
  function automatic rsp_t divide_answer(req_t rq);
    logic        signs_on, want_rem, num_neg, den_neg, carry;
    logic [63:0] num, den, quo, rem;
    int          i;
    rsp_t        a;
    signs_on = (rq.action == ACT_SQUO) || (rq.action == ACT_SREM);
    want_rem = (rq.action == ACT_UREM) || (rq.action == ACT_SREM);
    num_neg  = signs_on && rq.dividend[63];
    den_neg  = signs_on && rq.divisor[63];
    num = num_neg ? -rq.dividend : rq.dividend;
    den = den_neg ? -rq.divisor : rq.divisor;
    if (rq.divisor == '0) begin
      quo = '1;
      rem = num;
    end else begin
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
        carry = rem[63];
        rem = {rem[62:0], num[i]};
        quo = {quo[62:0], 1'b0};
        if (carry || rem >= den) begin
          rem = rem - den;
          quo[0] = 1'b1;
        end
      end
    end
    if (want_rem)
      a.result = num_neg ? -rem : rem;
    else
      a.result = (num_neg != den_neg) ? -quo : quo;
    a.div_by_zero = (rq.divisor == '0);
    return a;
  endfunction

  // Operands lean toward narrow values, sign corners and zero so that short
  // quotients, negative operands and divide by zero all show up often.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5: v = v >> $urandom_range(63);
      6: v = -(v >> $urandom_range(63));
      7: v = 64'($urandom_range(16));
      8: begin
        v = 64'($urandom_range(16));
        v = -v;
      end
      default: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, 63'b0};
          3: v = {1'b0, {63{1'b1}}};
          default: v = 64'd1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_row(logic [1:0] act, logic [63:0] num, logic [63:0] den,
                         bit known, logic [63:0] res, logic dz);
    stim_row_t row;
    row.rq.action   = act;
    row.rq.dividend = num;
    row.rq.divisor  = den;
    row.known       = known;
    row.ans.result  = res;
    row.ans.div_by_zero = dz;
    stim_table.push_back(row);
  endtask

  // Offers one beat and holds it until the block takes it, then maybe idles.
  task automatic send_beat(req_t rq, bit known, rsp_t typed);
    int gap;
    start   <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    answers_due.push_back(known ? typed : divide_answer(rq));
    beats_sent++;
    if (rq.divisor == '0) zero_divs++;
    if (rq.action == ACT_SQUO || rq.action == ACT_SREM) signed_beats++;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 80);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $error("result beat with no request outstanding: result %h", response.result);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        results_seen++;
        if (response.result !== want.result) begin
          $error("result: expected %h, got %h", want.result, response.result);
          fail_count++;
        end
        if (response.div_by_zero !== want.div_by_zero) begin
          $error("div_by_zero: expected %b, got %b", want.div_by_zero,
                 response.div_by_zero);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t rq;
    rsp_t none;
    int   phase;
    int   n;
    none = '0;

    // Corners with the answer typed in, then cases left to the predictor.
    add_row(ACT_UQUO, '1, 64'd1, 1'b1, '1, 1'b0);
    add_row(ACT_UQUO, '0, '1, 1'b1, '0, 1'b0);
    add_row(ACT_UQUO, 64'h1234, '0, 1'b1, '1, 1'b1);
    add_row(ACT_UREM, 64'hDEAD_BEEF_0000_0001, '0, 1'b1, 64'hDEAD_BEEF_0000_0001, 1'b1);
    add_row(ACT_SQUO, 64'd5, '0, 1'b1, '1, 1'b1);
    add_row(ACT_SQUO, -64'd5, '0, 1'b1, 64'd1, 1'b1);
    add_row(ACT_SREM, -64'd5, '0, 1'b1, -64'd5, 1'b1);
    add_row(ACT_SQUO, {1'b1, 63'b0}, '1, 1'b1, {1'b1, 63'b0}, 1'b0);
    add_row(ACT_SREM, {1'b1, 63'b0}, '1, 1'b1, '0, 1'b0);
    add_row(ACT_UQUO, {1'b1, 63'b0}, '1, 1'b1, '0, 1'b0);
    add_row(ACT_UREM, {1'b1, 63'b0}, '1, 1'b1, {1'b1, 63'b0}, 1'b0);
    add_row(ACT_UQUO, '1, '1, 1'b1, 64'd1, 1'b0);
    add_row(ACT_SQUO, {1'b1, 63'b0}, 64'd1, 1'b1, {1'b1, 63'b0}, 1'b0);
    add_row(ACT_SQUO, {1'b0, {63{1'b1}}}, '1, 1'b1, {1'b1, 62'b0, 1'b1}, 1'b0);
    add_row(ACT_UQUO, 64'd100, 64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_UREM, 64'd100, 64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SQUO, -64'd100, 64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SREM, -64'd100, 64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SQUO, 64'd100, -64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SREM, 64'd100, -64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SQUO, -64'd100, -64'd7, 1'b0, '0, 1'b0);
    add_row(ACT_SREM, -64'd7, 64'd100, 1'b0, '0, 1'b0);
    add_row(ACT_UREM, 64'd3, 64'd10, 1'b0, '0, 1'b0);
    add_row(ACT_UQUO, '1, {1'b1, 62'b0, 1'b1}, 1'b0, '0, 1'b0);
    add_row(ACT_UREM, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_FFFF_FFFF, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 16;
    foreach (stim_table[i]) send_beat(stim_table[i].rq, stim_table[i].known,
                                      stim_table[i].ans);
    // Let the pipeline run dry once before random traffic starts.
    drain();

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 88 : 0;
      for (n = 0; n < RANDOM_BEATS / 3; n++) begin
        rq.action   = 2'($urandom_range(3));
        rq.dividend = pick_operand();
        rq.divisor  = pick_operand();
        send_beat(rq, 1'b0, none);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d signed, %0d divide by zero), checked %0d results.",
             beats_sent, signed_beats, zero_divs, results_seen);
    $display("Sender idling ran at 16, 88 and 0 percent, with full drains between phases.");
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dm64_pkg.sv
rtl/dm64_alu.sv
rtl/divide_modulo_64.sv
dv/tb_divide_modulo_64.sv
